// ===== sv/cqa_pkg.sv =====
// Shared types and constants for the mixed real/complex/quaternion ALU.
// Holds the request/response payload structs, operation and kind codes,
// and the Hamilton product term tables. No dependencies.
package cqa_pkg;

	localparam logic [2:0] MODE_ADD = 3'd0;
	localparam logic [2:0] MODE_SUB = 3'd1;
	localparam logic [2:0] MODE_MUL = 3'd2;
	localparam logic [2:0] MODE_DIV = 3'd3;
	localparam logic [2:0] MODE_EQ  = 3'd4;

	localparam logic [1:0] KIND_REAL    = 2'd0;
	localparam logic [1:0] KIND_COMPLEX = 2'd1;
	localparam logic [1:0] KIND_QUAT    = 2'd2;

	// Bit (4*r + t) is set where term t of result part r enters with a minus sign.
	localparam logic [15:0] TERM_NEG = 16'h428E;

	typedef struct packed {
		logic [2:0]         mode;
		logic [1:0]         kind_a;
		logic signed [31:0] a0;
		logic signed [31:0] a1;
		logic signed [31:0] a2;
		logic signed [31:0] a3;
		logic [1:0]         kind_b;
		logic signed [31:0] b0;
		logic signed [31:0] b1;
		logic signed [31:0] b2;
		logic signed [31:0] b3;
	} req_t;

	typedef struct packed {
		logic [1:0]         kind_r;
		logic signed [31:0] r0;
		logic signed [31:0] r1;
		logic signed [31:0] r2;
		logic signed [31:0] r3;
		logic               is_equal;
		logic               div_zero;
		logic               overflow;
	} rsp_t;

	// Per-item control that rides along the pipeline.
	typedef struct packed {
		logic [2:0] mode;
		logic [1:0] kr;
		logic       eq;
		logic       dz;
	} ctl_t;

	// Kind code three is handled as quaternion.
	function automatic logic [1:0] clamp_kind(input logic [1:0] k);
		return (k == 2'd3) ? KIND_QUAT : k;
	endfunction

	function automatic logic lane_used(input logic [1:0] k, input int lane);
		logic r;
		case (k)
			KIND_REAL:    r = (lane == 0);
			KIND_COMPLEX: r = (lane < 2);
			default:      r = 1'b1;
		endcase
		return r;
	endfunction

	// Sign of a*conj(b) or a*b term; conjugation flips every b part but the real one.
	function automatic logic term_neg(input int r, input int t, input logic conj);
		return TERM_NEG[4*r + t] ^ (conj && ((r ^ t) != 0));
	endfunction

endpackage

// ===== sv/cqa_div_step.sv =====
// One restoring division step for one lane of the quotient pipeline.
// Shifts one numerator bit into the partial remainder and registers the
// result. Uses no package.
module cqa_div_step #(
	parameter int W  = 32,
	parameter int DW = 65
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] d,
	input  logic [DW-1:0] rem_i,
	input  logic [W-1:0]  nlo_i,
	input  logic [W-1:0]  quo_i,
	output logic [DW-1:0] rem_o,
	output logic [W-1:0]  nlo_o,
	output logic [W-1:0]  quo_o
);

	logic [DW:0] trial;
	logic        ge;

	assign trial = {rem_i, nlo_i[W-1]};
	assign ge    = (trial >= {1'b0, d});

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? DW'(trial - {1'b0, d}) : DW'(trial);
			nlo_o <= {nlo_i[W-2:0], 1'b0};
			quo_o <= {quo_i[W-2:0], ge};
		end
	end

endmodule

// ===== sv/complex_quaternion_alu.sv =====
// Mixed real/complex/quaternion ALU on signed Q(WORD_BITS-FRAC_BITS).FRAC_BITS
// values: add, subtract, Hamilton product, right quotient a*conj(b)/|b|^2 and
// equality, one result per request. A request is taken every cycle unless
// the pipeline holds; the quotient unit retires one quotient bit per stage
// for all four parts. The whole pipeline holds while a finished result is
// stalled.
module complex_quaternion_alu import cqa_pkg::*; #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int SW = 2*W + 2;      // exact sum of four products
	localparam int MW = 2*W + 1;      // magnitude of that sum
	localparam int DW = 2*W + 1;      // divisor norm
	localparam int QW = MW + 1;       // scaled magnitude before saturation
	localparam int NW = MW + F;       // dividend
	localparam int XW = 3*W + F + 2;  // room for the range check

	logic en;
	assign en        = !(rsp_valid && rsp_stall);
	assign req_stall = !en;

	// Stage 1: operand decode, add/sub and equality.
	logic signed [W-1:0] a_c [4];
	logic signed [W-1:0] b_c [4];
	logic signed [W-1:0] as_c [4];
	logic [3:0]          aso_c;
	logic [1:0]          ka, kb;
	logic [31:0]         fa [4];
	logic [31:0]         fb [4];
	logic signed [W:0]   sum_c;

	always_comb begin
		ka = clamp_kind(req.kind_a);
		kb = clamp_kind(req.kind_b);
		fa[0] = req.a0; fa[1] = req.a1; fa[2] = req.a2; fa[3] = req.a3;
		fb[0] = req.b0; fb[1] = req.b1; fb[2] = req.b2; fb[3] = req.b3;
		for (int i = 0; i < 4; i++) begin
			a_c[i] = lane_used(ka, i) ? W'(fa[i]) : '0;
			b_c[i] = lane_used(kb, i) ? W'(fb[i]) : '0;
			if (req.mode == MODE_SUB)
				sum_c = (W+1)'(a_c[i]) - (W+1)'(b_c[i]);
			else
				sum_c = (W+1)'(a_c[i]) + (W+1)'(b_c[i]);
			aso_c[i] = (sum_c[W] != sum_c[W-1]);
			if (aso_c[i])
				as_c[i] = sum_c[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			else
				as_c[i] = sum_c[W-1:0];
		end
	end

	logic                v_s1;
	ctl_t                ctl_s1;
	logic signed [W-1:0] a_s1 [4];
	logic signed [W-1:0] b_s1 [4];
	logic signed [W-1:0] as_s1 [4];
	logic [3:0]          aso_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= req_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1.mode <= req.mode;
			ctl_s1.kr   <= (ka > kb) ? ka : kb;
			ctl_s1.eq   <= (a_c[0] == b_c[0]) && (a_c[1] == b_c[1]) &&
			               (a_c[2] == b_c[2]) && (a_c[3] == b_c[3]);
			ctl_s1.dz   <= 1'b0;
			a_s1        <= a_c;
			b_s1        <= b_c;
			as_s1       <= as_c;
			aso_s1      <= aso_c;
		end
	end

	// Stage 2: the sixteen partial products and the four squares.
	logic                  v_s2;
	ctl_t                  ctl_s2;
	logic signed [2*W-1:0] p_s2 [4][4];
	logic [2*W-1:0]        sq_s2 [4];
	logic signed [W-1:0]   as_s2 [4];
	logic [3:0]            aso_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++)
					p_s2[i][j] <= (2*W)'(a_s1[j]) * (2*W)'(b_s1[i ^ j]);
				sq_s2[i] <= $unsigned((2*W)'(b_s1[i]) * (2*W)'(b_s1[i]));
			end
			ctl_s2 <= ctl_s1;
			as_s2  <= as_s1;
			aso_s2 <= aso_s1;
		end
	end

	// Stage 3: exact part sums and divisor norm.
	logic                 v_s3;
	ctl_t                 ctl_s3;
	logic signed [SW-1:0] s_c [4];
	logic signed [SW-1:0] s_s3 [4];
	logic [DW-1:0]        d_c, d_s3;
	logic signed [W-1:0]  as_s3 [4];
	logic [3:0]           aso_s3;

	always_comb begin
		d_c = '0;
		for (int i = 0; i < 4; i++) begin
			s_c[i] = '0;
			for (int j = 0; j < 4; j++) begin
				if (term_neg(i, j, ctl_s2.mode == MODE_DIV))
					s_c[i] = s_c[i] - SW'(p_s2[i][j]);
				else
					s_c[i] = s_c[i] + SW'(p_s2[i][j]);
			end
			d_c = d_c + DW'(sq_s2[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s3   <= s_c;
			d_s3   <= d_c;
			ctl_s3 <= ctl_s2;
			as_s3  <= as_s2;
			aso_s3 <= aso_s2;
		end
	end

	// Stage 4: sign and magnitude of each sum, zero-norm check.
	logic                v_s4;
	ctl_t                ctl_s4;
	logic [3:0]          neg_s4;
	logic [MW-1:0]       mag_s4 [4];
	logic [DW-1:0]       d_s4;
	logic signed [W-1:0] as_s4 [4];
	logic [3:0]          aso_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				neg_s4[i] <= s_s3[i][SW-1];
				mag_s4[i] <= MW'(s_s3[i][SW-1] ? -s_s3[i] : s_s3[i]);
			end
			d_s4       <= d_s3;
			ctl_s4     <= '{mode: ctl_s3.mode, kr: ctl_s3.kr, eq: ctl_s3.eq,
			                dz: (ctl_s3.mode == MODE_DIV) && (d_s3 == '0)};
			as_s4      <= as_s3;
			aso_s4     <= aso_s3;
		end
	end

	// Stage 5: per-part setup. Add/sub and multiply finish their magnitude
	// here; a quotient that would not fit in W bits is flagged up front.
	logic [3:0]        lneg_c, lovf_c, udiv_c;
	logic [QW-1:0]     lmag_c [4];
	logic [DW-1:0]     rem0_c [4];
	logic [W-1:0]      nlo0_c [4];
	logic [NW-1:0]     num_c;
	logic signed [W:0] asx_c;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			lneg_c[i] = 1'b0;
			lovf_c[i] = 1'b0;
			udiv_c[i] = 1'b0;
			lmag_c[i] = '0;
			num_c     = NW'(mag_s4[i]) << F;
			asx_c     = (W+1)'(as_s4[i]);
			rem0_c[i] = DW'(num_c >> W);
			nlo0_c[i] = num_c[W-1:0];
			case (ctl_s4.mode)
				MODE_ADD, MODE_SUB: begin
					lneg_c[i] = asx_c[W];
					lmag_c[i] = QW'(asx_c[W] ? -asx_c : asx_c);
					lovf_c[i] = aso_s4[i];
				end
				MODE_MUL: begin
					lneg_c[i] = neg_s4[i];
					lmag_c[i] = QW'(mag_s4[i] >> F) + QW'(mag_s4[i][F-1]);
				end
				MODE_DIV: begin
					if (!ctl_s4.dz) begin
						lneg_c[i] = neg_s4[i];
						lovf_c[i] = (XW'(num_c) >= (XW'(d_s4) << W));
						udiv_c[i] = !lovf_c[i];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Quotient pipeline: index 0 is stage 5, index k is after k steps.
	logic          v_d    [W+1];
	ctl_t          ctl_d  [W+1];
	logic [DW-1:0] d_d    [W+1];
	logic [3:0]    lneg_d [W+1];
	logic [3:0]    lovf_d [W+1];
	logic [3:0]    udiv_d [W+1];
	logic [QW-1:0] lmag_d [W+1][4];
	logic [DW-1:0] rem_d  [W+1][4];
	logic [W-1:0]  nlo_d  [W+1][4];
	logic [W-1:0]  quo_d  [W+1][4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_d[0] <= 1'b0;
		else if (en)
			v_d[0] <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_d[0]  <= ctl_s4;
			d_d[0]    <= d_s4;
			lneg_d[0] <= lneg_c;
			lovf_d[0] <= lovf_c;
			udiv_d[0] <= udiv_c;
			lmag_d[0] <= lmag_c;
			rem_d[0]  <= rem0_c;
			nlo_d[0]  <= nlo0_c;
			for (int i = 0; i < 4; i++)
				quo_d[0][i] <= '0;
		end
	end

	for (genvar k = 1; k <= W; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_d[k] <= 1'b0;
			else if (en)
				v_d[k] <= v_d[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctl_d[k]  <= ctl_d[k-1];
				d_d[k]    <= d_d[k-1];
				lneg_d[k] <= lneg_d[k-1];
				lovf_d[k] <= lovf_d[k-1];
				udiv_d[k] <= udiv_d[k-1];
				lmag_d[k] <= lmag_d[k-1];
			end
		end

		for (genvar l = 0; l < 4; l++) begin : g_lane
			cqa_div_step #(.W(W), .DW(DW)) u_step (
				.clk   (clk),
				.en    (en),
				.d     (d_d[k-1]),
				.rem_i (rem_d[k-1][l]),
				.nlo_i (nlo_d[k-1][l]),
				.quo_i (quo_d[k-1][l]),
				.rem_o (rem_d[k][l]),
				.nlo_o (nlo_d[k][l]),
				.quo_o (quo_d[k][l])
			);
		end
	end

	// Stage 6: round the quotient to nearest, ties away from zero; other modes pass their magnitude through.
	logic          v_s6;
	ctl_t          ctl_s6;
	logic [3:0]    neg_s6, ovf_s6;
	logic [QW-1:0] mf_s6 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (en)
			v_s6 <= v_d[W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				if (udiv_d[W][i])
					mf_s6[i] <= QW'(quo_d[W][i]) +
					            QW'({rem_d[W][i], 1'b0} >= {1'b0, d_d[W]});
				else
					mf_s6[i] <= lmag_d[W][i];
			end
			neg_s6 <= lneg_d[W];
			ovf_s6 <= lovf_d[W];
			ctl_s6 <= ctl_d[W];
		end
	end

	// Stage 7: saturate, restore sign, clear parts beyond the result kind.
	logic [W-1:0]  val_c [4];
	logic [3:0]    sat_c;
	logic [QW-1:0] lim_c;
	logic [QW-1:0] mg_c;
	rsp_t          rsp_c;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			lim_c    = (QW'(1) << (W-1)) - QW'(!neg_s6[i]);
			sat_c[i] = ovf_s6[i] || (mf_s6[i] > lim_c);
			mg_c     = sat_c[i] ? lim_c : mf_s6[i];
			val_c[i] = neg_s6[i] ? W'(-mg_c) : W'(mg_c);
			if (!lane_used(ctl_s6.kr, i))
				val_c[i] = '0;
		end
		rsp_c.kind_r   = ctl_s6.kr;
		rsp_c.r0       = 32'(val_c[0]);
		rsp_c.r1       = 32'(val_c[1]);
		rsp_c.r2       = 32'(val_c[2]);
		rsp_c.r3       = 32'(val_c[3]);
		rsp_c.is_equal = (ctl_s6.mode == MODE_EQ) && ctl_s6.eq;
		rsp_c.div_zero = (ctl_s6.mode == MODE_DIV) && ctl_s6.dz;
		rsp_c.overflow = |sat_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid <= 1'b0;
		else if (en)
			rsp_valid <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en)
			rsp <= rsp_c;
	end

endmodule

// ===== sv/cqa_checker.sv =====
// Port-level checks for the mixed real/complex/quaternion ALU, bound to
// the top level. Depends on cqa_pkg for the payload types and codes.
module cqa_checker import cqa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// The pipeline holds exactly when a finished result cannot transfer.
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall == (rsp_valid && rsp_stall))
		else $error("request stall does not follow the output stall");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.div_zero |-> rsp.r0 == 0 && rsp.r1 == 0 && rsp.r2 == 0 &&
			rsp.r3 == 0 && !rsp.overflow && !rsp.is_equal)
		else $error("zero divisor result is not cleared");

	a_equal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_equal |-> rsp.r0 == 0 && rsp.r1 == 0 && rsp.r2 == 0 &&
			rsp.r3 == 0 && !rsp.overflow)
		else $error("equality result carries data");

	a_real_parts: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind_r == KIND_REAL |-> rsp.r1 == 0 && rsp.r2 == 0 &&
			rsp.r3 == 0)
		else $error("real result has imaginary parts");

endmodule

bind complex_quaternion_alu cqa_checker u_cqa_checker (.*);

// ===== dv/tb_complex_quaternion_alu.sv =====
// Testbench for the mixed real/complex/quaternion ALU: directed and random
// operand pairs, checked against an in-bench fixed-point predictor.
// Depends on cqa_pkg and complex_quaternion_alu.
`timescale 1ns / 1ps

module tb_complex_quaternion_alu;
	import cqa_pkg::*;

	localparam int WB = 32;
	localparam int FB = 16;
	localparam logic [2:0] MODE_BAD = 3'd5;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	rsp_t expected_q[$];
	int errors;
	int burst_left;

	complex_quaternion_alu dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("[complex_quaternion_alu] ERROR");
		$finish;
	end

	// Clamp a wide value to the signed word range.
	function automatic logic signed [31:0] sat_word(input logic signed [199:0] v,
			inout logic ovf);
		logic signed [199:0] hi;
		logic signed [199:0] lo;
		hi = (200'sd1 <<< (WB - 1)) - 1;
		lo = -(200'sd1 <<< (WB - 1));
		if (v > hi) begin
			ovf = 1'b1;
			return hi[31:0];
		end
		if (v < lo) begin
			ovf = 1'b1;
			return lo[31:0];
		end
		return v[31:0];
	endfunction

	function automatic rsp_t predict_alu(input req_t q);
		logic [1:0] ka, kb, kr;
		logic signed [199:0] a[4];
		logic signed [199:0] b[4];
		logic signed [199:0] c[4];
		logic signed [199:0] s, mag, num, quo, rem, d;
		logic signed [31:0] r[4];
		logic ovf, neg;
		int nc[3];
		int cix[4][4];
		int sg[4][4];
		rsp_t o;
		nc = '{1, 2, 4};
		cix = '{'{0,1,2,3}, '{1,0,3,2}, '{2,3,0,1}, '{3,2,1,0}};
		sg = '{'{1,-1,-1,-1}, '{1,1,1,-1}, '{1,-1,1,1}, '{1,1,-1,1}};
		ka = (q.kind_a == 2'd3) ? KIND_QUAT : q.kind_a;
		kb = (q.kind_b == 2'd3) ? KIND_QUAT : q.kind_b;
		kr = (ka > kb) ? ka : kb;
		a[0] = q.a0; a[1] = q.a1; a[2] = q.a2; a[3] = q.a3;
		b[0] = q.b0; b[1] = q.b1; b[2] = q.b2; b[3] = q.b3;
		for (int i = 0; i < 4; i++) begin
			if (i >= nc[ka]) a[i] = 0;
			if (i >= nc[kb]) b[i] = 0;
			r[i] = '0;
		end
		o = '0;
		ovf = 1'b0;
		o.kind_r = kr;
		case (q.mode)
			MODE_ADD, MODE_SUB: begin
				for (int i = 0; i < 4; i++)
					r[i] = sat_word((q.mode == MODE_ADD) ? a[i] + b[i] : a[i] - b[i], ovf);
			end
			MODE_MUL, MODE_DIV: begin
				d = 0;
				for (int i = 0; i < 4; i++) begin
					c[i] = (q.mode == MODE_DIV && i > 0) ? -b[i] : b[i];
					d += b[i] * b[i];
				end
				if (q.mode == MODE_DIV && d == 0) begin
					o.div_zero = 1'b1;
				end else begin
					for (int i = 0; i < 4; i++) begin
						s = 0;
						for (int j = 0; j < 4; j++)
							s += sg[i][j] * (a[j] * c[cix[i][j]]);
						neg = s < 0;
						mag = neg ? -s : s;
						if (q.mode == MODE_DIV) begin
							num = mag <<< FB;
							quo = num / d;
							rem = num % d;
							if (2 * rem >= d) quo += 1;
						end else begin
							quo = (mag >>> FB) + mag[FB-1];
						end
						r[i] = sat_word(neg ? -quo : quo, ovf);
					end
				end
			end
			MODE_EQ: o.is_equal = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2])
					&& (a[3] == b[3]);
			default: ;
		endcase
		if (q.mode > MODE_EQ) ovf = 1'b0;
		for (int i = 0; i < 4; i++)
			if (i >= nc[kr]) r[i] = '0;
		o.r0 = r[0]; o.r1 = r[1]; o.r2 = r[2]; o.r3 = r[3];
		o.overflow = ovf;
		return o;
	endfunction

	// Receiver stalls at random, with stall-free windows in between.
	initial begin
		int phase;
		rsp_stall = 1'b0;
		phase = 0;
		forever begin
			@(negedge clk);
			phase++;
			if ((phase / 64) % 3 == 0) rsp_stall <= 1'b0;
			else rsp_stall <= ($urandom_range(0, 3) == 0);
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_q.size() == 0) begin
				$display("%t unexpected result %p", $realtime, rsp);
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (rsp !== want) begin
					$display("%t mismatch: expected %p actual %p", $realtime, want, rsp);
					errors++;
				end
			end
		end
	end

	// Sends one request; the sender may idle between bursts of random length.
	task automatic send_req(input req_t q);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 4);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		req_valid <= 1'b1;
		req <= q;
		do @(posedge clk); while (req_stall);
		expected_q.push_back(predict_alu(q));
		@(negedge clk);
	endtask

	function automatic logic [31:0] rnd_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 32'h3_ffff) - 32'h2_0000;
			3: return $urandom_range(0, 32'h3ff_ffff) - 32'h200_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic req_t rnd_req(input logic [2:0] m);
		req_t q;
		q.mode = m;
		q.kind_a = 2'($urandom_range(0, 3));
		q.kind_b = 2'($urandom_range(0, 3));
		q.a0 = rnd_word(); q.a1 = rnd_word(); q.a2 = rnd_word(); q.a3 = rnd_word();
		q.b0 = rnd_word(); q.b1 = rnd_word(); q.b2 = rnd_word(); q.b3 = rnd_word();
		return q;
	endfunction

	function automatic req_t mk(input logic [2:0] m, input logic [1:0] ka,
			input logic [31:0] av, input logic [1:0] kb, input logic [31:0] bv);
		req_t q;
		q.mode = m;
		q.kind_a = ka; q.kind_b = kb;
		q.a0 = av; q.a1 = av; q.a2 = av; q.a3 = av;
		q.b0 = bv; q.b1 = bv; q.b2 = bv; q.b3 = bv;
		return q;
	endfunction

	task automatic test_directed();
		req_t q;
		send_req(mk(MODE_ADD, KIND_QUAT, 32'h7fff_ffff, KIND_QUAT, 32'h7fff_ffff));
		send_req(mk(MODE_SUB, KIND_QUAT, 32'h8000_0000, KIND_QUAT, 32'h7fff_ffff));
		send_req(mk(MODE_ADD, KIND_REAL, 32'h0001_0000, KIND_COMPLEX, 32'hffff_0000));
		send_req(mk(MODE_MUL, KIND_QUAT, 32'h8000_0000, KIND_QUAT, 32'h8000_0000));
		send_req(mk(MODE_MUL, KIND_COMPLEX, 32'h0000_8000, KIND_COMPLEX, 32'h0000_0001));
		send_req(mk(MODE_MUL, 2'd3, 32'h0002_0000, KIND_REAL, 32'hfffe_8000));
		send_req(mk(MODE_DIV, KIND_QUAT, 32'h0001_0000, KIND_QUAT, 32'h0000_0000));
		send_req(mk(MODE_DIV, KIND_QUAT, 32'h7fff_ffff, KIND_REAL, 32'h0000_0001));
		send_req(mk(MODE_DIV, KIND_COMPLEX, 32'h0003_0000, KIND_QUAT, 32'h0002_0000));
		send_req(mk(MODE_DIV, KIND_REAL, 32'h0001_0000, KIND_REAL, 32'h0003_0000));
		send_req(mk(MODE_EQ, KIND_QUAT, 32'h1234_5678, 2'd3, 32'h1234_5678));
		// Ignored components must not affect equality.
		q = mk(MODE_EQ, KIND_REAL, 32'h5, KIND_COMPLEX, 32'h5);
		q.a1 = 32'h9; q.b1 = 32'h0;
		send_req(q);
		send_req(mk(MODE_EQ, KIND_COMPLEX, 32'h1, KIND_COMPLEX, 32'h2));
		for (int m = MODE_BAD; m <= 7; m++)
			send_req(mk(m[2:0], KIND_QUAT, 32'h7fff_ffff, KIND_QUAT, 32'h7fff_ffff));
		send_req(mk(MODE_ADD, KIND_COMPLEX, 32'hffff_ffff, KIND_REAL, 32'h0));
	endtask

	task automatic test_random(input int count);
		logic [2:0] m;
		for (int n = 0; n < count; n++) begin
			m = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
			                                 : 3'($urandom_range(0, 4));
			send_req(rnd_req(m));
		end
	endtask

	initial begin
		int guard;
		errors = 0;
		burst_left = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(530);
		req_valid <= 1'b0;
		guard = 0;
		while (expected_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (WB + 20) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("[complex_quaternion_alu] OK");
		end else begin
			$display("[complex_quaternion_alu] ERROR");
		end
		$finish;
	end

endmodule
